// ----- hdl/cpcc_pkg.sv -----
// shared types and constants of the current pulse position counter
package cpcc_pkg;

  localparam int DIV_W = 8;

  localparam logic [7:0] LIMIT_RESET = 8'd50;
  localparam logic signed [11:0] CUR_ON_MIN = 12'sd1;
  localparam logic signed [11:0] CUR_CAL_MIN = 12'sd3;
  localparam logic signed [11:0] CUR_CAL_MAX = 12'sd250;
  localparam logic signed [10:0] FRAC_WRAP = 11'sd200;
  localparam logic [7:0] START_DELAY = 8'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic               op;
    logic [1:0]         drive_index;
    logic [1:0]         direction;
    logic signed [11:0] motor_current;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         drive_echo;
    logic signed [15:0] position;
  } out_word_t;

endpackage

// ----- hdl/current_pulse_position_counter_unit.sv -----
// top level: per-drive position estimate from motor current samples
//
//  channel | ports                        | direction
//  input   | in_valid, in_stall, in_data  | item in, stall out
//  result  | out_valid, out_stall, out_data | word out, stall in
//  config  | cfg_we, cfg_wdata            | off_time_limit write
//
// each word passes through 8 steps of the shared serial divider, the registered divider
// done, and an update step that writes the result register, then returns to idle with
// in_stall low; in_stall is high from accept until that return to idle.
// the next word is taken once the update is done, even while the result waits.
// reset clears all per-drive state and sets off_time_limit to 50.
// out_stall holds the result register; the update waits only if it is still full.
module current_pulse_position_counter_unit #(
  parameter int DRIVE_COUNT = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpcc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpcc_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import cpcc_pkg::*;

  localparam int DRV_W = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [7:0] lim_r;

  in_word_t item_r;
  logic     item_ok_r;

  logic signed [15:0] pos_r  [DRIVE_COUNT];
  logic signed [9:0]  frac_r [DRIVE_COUNT];
  logic [7:0]         off_r  [DRIVE_COUNT];
  logic [7:0]         on_r   [DRIVE_COUNT];

  out_word_t out_data_r;
  logic      out_valid_r;

  logic             in_accept;
  logic [7:0]       cal_cur;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic             upd_fire;

  logic [DRV_W-1:0]   idx;
  logic signed [15:0] pos_nxt;
  logic signed [10:0] frac_sum;
  logic signed [9:0]  frac_nxt;
  logic [7:0]         off_nxt, on_nxt;
  logic               counting;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // current clamped to the calibrated range
  always_comb begin
    if (in_data.motor_current < CUR_CAL_MIN) begin
      cal_cur = CUR_CAL_MIN[7:0];
    end else if (in_data.motor_current > CUR_CAL_MAX) begin
      cal_cur = CUR_CAL_MAX[7:0];
    end else begin
      cal_cur = in_data.motor_current[7:0];
    end
  end

  assign div_dividend = CUR_CAL_MAX[7:0] - cal_cur;

  cpcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .dividend (div_dividend),
    .divisor  (cal_cur),
    .done     (div_done),
    .quotient (div_q)
  );

  assign idx      = item_r.drive_index[DRV_W-1:0];
  assign upd_fire = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  always_comb begin
    pos_nxt  = pos_r[idx];
    frac_nxt = frac_r[idx];
    off_nxt  = off_r[idx];
    on_nxt   = on_r[idx];
    frac_sum = '0;
    counting = 1'b0;
    if (item_r.op == OP_CLEAR) begin
      pos_nxt = '0;
    end else begin
      if (item_r.motor_current < CUR_ON_MIN) begin
        if (off_r[idx] < lim_r) begin
          off_nxt = off_r[idx] + 8'd1;
        end
        on_nxt   = '0;
        frac_nxt = '0;
      end else begin
        off_nxt = '0;
        if (on_r[idx] < lim_r) begin
          on_nxt = on_r[idx] + 8'd1;
        end
      end
      counting = (on_nxt > START_DELAY) && (off_nxt < lim_r);
      if (counting && item_r.direction == DIR_UP) begin
        frac_sum = 11'(frac_nxt) + $signed({3'b000, div_q});
        if (frac_sum > FRAC_WRAP) begin
          frac_nxt = 10'(frac_sum - FRAC_WRAP);
          pos_nxt  = pos_nxt + 16'sd2;
        end else begin
          frac_nxt = 10'(frac_sum);
          pos_nxt  = pos_nxt + 16'sd1;
        end
      end else if (counting && item_r.direction == DIR_DOWN) begin
        frac_sum = 11'(frac_nxt) - $signed({3'b000, div_q});
        if (frac_sum < 0) begin
          frac_nxt = 10'(frac_sum + FRAC_WRAP);
          pos_nxt  = pos_nxt - 16'sd2;
        end else begin
          frac_nxt = 10'(frac_sum);
          pos_nxt  = pos_nxt - 16'sd1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lim_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        pos_r[i]  <= '0;
        frac_r[i] <= '0;
        off_r[i]  <= '0;
        on_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (upd_fire && item_ok_r) begin
        pos_r[idx]  <= pos_nxt;
        frac_r[idx] <= frac_nxt;
        off_r[idx]  <= off_nxt;
        on_r[idx]   <= on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r    <= in_data;
      item_ok_r <= (32'(in_data.drive_index) < DRIVE_COUNT);
    end
    if (upd_fire) begin
      out_data_r.drive_echo <= item_r.drive_index;
      out_data_r.position   <= item_ok_r ? pos_nxt : 16'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_bad_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (32'(out_data_r.drive_echo) >= DRIVE_COUNT))
      |-> (out_data_r.position == 16'sd0))
    else $error("out of range drive returned nonzero position");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && item_ok_r) |-> (frac_nxt >= 0 && 11'(frac_nxt) <= FRAC_WRAP))
    else $error("fraction accumulator out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

// ----- hdl/cpcc_div.sv -----
// restoring serial divider, one quotient bit per cycle
module cpcc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpcc_pkg::DIV_W-1:0] dividend,
  input  logic [cpcc_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [cpcc_pkg::DIV_W-1:0] quotient
);
  import cpcc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // dividend bits shift out the top as quotient bits shift in
      if (diff[DIV_W+1]) begin
        rem_nxt = rem_sh[DIV_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DIV_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");
`endif

endmodule
